// ===== rtl/core/febs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// febs_pkg
// Shared types and constants of the face expression and blink sequencer.
// ----------------------------------------------------------------------------
package febs_pkg;

    localparam logic [16:0] Q_ONE          = 17'h10000;
    localparam logic [25:0] MIN_FADE_US    = 26'd10000;
    localparam logic [25:0] CLOSED_HOLD_US = 26'd40000;
    localparam logic [26:0] T_MAX          = 27'h3FFFFFF;
    localparam logic [31:0] LFSR_TAPS      = 32'h80200003;
    localparam logic [5:0]  EXPR_LIMIT     = 6'd32;
    localparam logic [25:0] RST_COUNTDOWN  = 26'd6000000;

    localparam logic [5:0]  DIV_LONG_STEPS  = 6'd32;
    localparam logic [5:0]  DIV_SHORT_STEPS = 6'd16;

    // configuration register indexes
    localparam logic [2:0] CFG_EXPR_COUNT  = 3'd0;
    localparam logic [2:0] CFG_DEFAULT     = 3'd1;
    localparam logic [2:0] CFG_FADE_TIME   = 3'd2;
    localparam logic [2:0] CFG_BLINK_DUR   = 3'd3;
    localparam logic [2:0] CFG_BLINK_MIN   = 3'd4;
    localparam logic [2:0] CFG_BLINK_MAX   = 3'd5;
    localparam logic [2:0] CFG_SEED        = 3'd6;

    // event opcodes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_SELECT = 3'd1;
    localparam logic [2:0] OP_NEXT   = 3'd2;
    localparam logic [2:0] OP_PREV   = 3'd3;
    localparam logic [2:0] OP_BOOP   = 3'd4;
    localparam logic [2:0] OP_BLINK  = 3'd5;

    // eyelid phases
    localparam logic [1:0] PH_OPEN    = 2'd0;
    localparam logic [1:0] PH_CLOSING = 2'd1;
    localparam logic [1:0] PH_CLOSED  = 2'd2;
    localparam logic [1:0] PH_OPENING = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic first;
        logic mid;
        logic fin;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_busy;
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/core/febs_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// febs_div
// Restoring divider, one quotient bit per cycle, 16 or 32 steps.
// ----------------------------------------------------------------------------
module febs_div import febs_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_long,
    input  wire logic [26:0] i_rem0,
    input  wire logic [31:0] i_num,
    input  wire logic [26:0] i_den,
    output logic             o_busy,
    output logic [31:0]      o_quo,
    output logic [26:0]      o_rem
);

    logic [5:0]  r_cnt, n_cnt;
    logic [26:0] r_rem, n_rem;
    logic [31:0] r_num, n_num;
    logic [31:0] r_quo, n_quo;
    logic [26:0] r_den, n_den;
    logic [27:0] s;
    logic        ge;

    // one shift and subtract step
    always_comb begin
        s     = {r_rem, r_num[31]};
        ge    = (s >= {1'b0, r_den});
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_num = r_num;
        n_quo = r_quo;
        n_den = r_den;
        if (i_start) begin
            n_cnt = i_long ? DIV_LONG_STEPS : DIV_SHORT_STEPS;
            n_rem = i_rem0;
            n_num = i_num;
            n_quo = '0;
            n_den = i_den;
        end else if (r_cnt != 6'd0) begin
            n_cnt = r_cnt - 6'd1;
            n_rem = ge ? 27'(s - {1'b0, r_den}) : s[26:0];
            n_num = {r_num[30:0], 1'b0};
            n_quo = {r_quo[30:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_num <= n_num;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_busy = (r_cnt != 6'd0);
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ===== rtl/core/febs_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// febs_dp
// Datapath: configuration, expression and eyelid state, divider, outputs.
// ----------------------------------------------------------------------------
module febs_dp import febs_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_status          o_sts,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [19:0] i_dt_us,
    input  wire logic [4:0]  i_expr_index,
    input  wire logic [25:0] i_boop_time_us,
    input  wire logic        i_eyes_closed,
    input  wire logic        i_blink_enabled,
    output logic [4:0]       o_current_expression,
    output logic [4:0]       o_previous_expression,
    output logic [16:0]      o_fade_weight,
    output logic [1:0]       o_blink_phase,
    output logic [16:0]      o_blink_weight,
    output logic             o_boop_active
);

    typedef enum logic [2:0] {
        K_NONE, K_FADE, K_CURSOR, K_CLOSE, K_OPEN, K_DRAW
    } t_kind;

    // configuration
    logic [5:0]  r_cnt_cfg;
    logic [25:0] r_fade_time, r_dur, r_bmin, r_bmax;

    // state
    logic [4:0]  r_shown, n_shown, r_faded, n_faded, r_cursor, n_cursor;
    logic [4:0]  r_saved, n_saved;
    logic [16:0] r_prog, n_prog, r_lid, n_lid;
    logic [25:0] r_boop, n_boop, r_timer, n_timer, r_cd, n_cd;
    logic [1:0]  r_phase, n_phase;
    logic [31:0] r_lfsr, n_lfsr;
    t_kind       r_kind, n_kind;
    logic        r_fade_sat, n_fade_sat;

    // latched event
    logic [2:0]  r_op;
    logic [19:0] r_dt;
    logic [4:0]  r_idx;
    logic [25:0] r_bt;
    logic        r_closed, r_en;

    // divider hookup
    logic        div_start, div_long, div_busy;
    logic [26:0] div_rem0, div_den, div_rem;
    logic [31:0] div_num, div_quo;

    // helpers
    logic [5:0]  eff_n;
    logic [25:0] f_eff;
    logic [26:0] t_sum;
    logic [25:0] t_sat;
    logic [26:0] two_t;
    logic        ramp_end;
    logic [31:0] lfsr_nx;
    logic [17:0] prog_sum;
    logic        chg_req;
    logic [4:0]  chg_tgt;

    febs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_long  (div_long),
        .i_rem0  (div_rem0),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign o_sts.div_busy = div_busy;

    // derived values
    always_comb begin
        eff_n    = (r_cnt_cfg > EXPR_LIMIT) ? EXPR_LIMIT : r_cnt_cfg;
        f_eff    = (r_fade_time < MIN_FADE_US) ? MIN_FADE_US : r_fade_time;
        t_sum    = {1'b0, r_timer} + {7'd0, r_dt};
        t_sat    = (t_sum > T_MAX) ? T_MAX[25:0] : t_sum[25:0];
        two_t    = {t_sat, 1'b0};
        ramp_end = (two_t >= {1'b0, r_dur});
        lfsr_nx  = r_lfsr[0] ? ({1'b0, r_lfsr[31:1]} ^ LFSR_TAPS) : {1'b0, r_lfsr[31:1]};
        prog_sum = {1'b0, r_prog} + {2'b00, div_quo[15:0]};
    end

    // event sequencing
    always_comb begin
        n_shown    = r_shown;
        n_faded    = r_faded;
        n_cursor   = r_cursor;
        n_saved    = r_saved;
        n_prog     = r_prog;
        n_lid      = r_lid;
        n_boop     = r_boop;
        n_timer    = r_timer;
        n_cd       = r_cd;
        n_phase    = r_phase;
        n_lfsr     = r_lfsr;
        n_kind     = r_kind;
        n_fade_sat = r_fade_sat;
        div_start  = 1'b0;
        div_long   = 1'b0;
        div_rem0   = '0;
        div_num    = '0;
        div_den    = '0;
        chg_req    = 1'b0;
        chg_tgt    = '0;

        // first step: direct events, start of fade or cursor division
        if (i_cmd.first) begin
            n_kind = K_NONE;
            case (r_op)
                OP_TICK: begin
                    n_fade_sat = ({6'd0, r_dt} >= f_eff);
                    if (r_prog < Q_ONE && ({6'd0, r_dt} < f_eff)) begin
                        div_start = 1'b1;
                        div_rem0  = {7'd0, r_dt};
                        div_den   = {1'b0, f_eff};
                        n_kind    = K_FADE;
                    end
                end
                OP_SELECT: begin
                    if ({1'b0, r_idx} < eff_n) begin
                        n_cursor = r_idx;
                        chg_req  = 1'b1;
                        chg_tgt  = r_idx;
                    end
                end
                OP_NEXT, OP_PREV: begin
                    if (eff_n != 6'd0) begin
                        div_start = 1'b1;
                        div_long  = 1'b1;
                        div_num   = (r_op == OP_NEXT) ?
                                    {26'd0, 6'({1'b0, r_cursor} + 6'd1)} :
                                    {26'd0, 6'({1'b0, r_cursor} + eff_n - 6'd1)};
                        div_den   = {21'd0, eff_n};
                        n_kind    = K_CURSOR;
                    end
                end
                OP_BOOP: begin
                    if (r_boop == 26'd0) n_saved = r_shown;
                    n_boop  = r_bt;
                    chg_req = 1'b1;
                    chg_tgt = r_idx;
                end
                OP_BLINK: begin
                    if (r_phase == PH_OPEN) begin
                        n_phase = PH_CLOSING;
                        n_timer = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        // middle step: cursor result, or fade, boop and eyelid update of a tick
        if (i_cmd.mid) begin
            n_kind = K_NONE;
            if (r_kind == K_CURSOR) begin
                n_cursor = div_rem[4:0];
                chg_req  = 1'b1;
                chg_tgt  = div_rem[4:0];
            end
            if (r_op == OP_TICK) begin
                if (r_prog < Q_ONE) begin
                    if (r_fade_sat || prog_sum > {1'b0, Q_ONE}) n_prog = Q_ONE;
                    else n_prog = prog_sum[16:0];
                end
                if (r_boop != 26'd0) begin
                    if ({6'd0, r_dt} >= r_boop) begin
                        n_boop  = '0;
                        chg_req = 1'b1;
                        chg_tgt = r_saved;
                    end else begin
                        n_boop = r_boop - {6'd0, r_dt};
                    end
                end
                if (r_closed) begin
                    n_phase = PH_CLOSED;
                    n_lid   = Q_ONE;
                end else if (!r_en) begin
                    n_phase = PH_OPEN;
                    n_lid   = '0;
                end else begin
                    case (r_phase)
                        PH_OPEN: begin
                            if ({6'd0, r_dt} >= r_cd) begin
                                n_cd    = '0;
                                n_phase = PH_CLOSING;
                                n_timer = '0;
                            end else begin
                                n_cd = r_cd - {6'd0, r_dt};
                            end
                        end
                        PH_CLOSING: begin
                            n_timer = t_sat;
                            if (ramp_end) begin
                                n_lid   = Q_ONE;
                                n_phase = PH_CLOSED;
                                n_timer = '0;
                            end else begin
                                div_start = 1'b1;
                                div_rem0  = two_t;
                                div_den   = {1'b0, r_dur};
                                n_kind    = K_CLOSE;
                            end
                        end
                        PH_CLOSED: begin
                            if (t_sat >= CLOSED_HOLD_US) begin
                                n_phase = PH_OPENING;
                                n_timer = '0;
                            end else begin
                                n_timer = t_sat;
                            end
                        end
                        PH_OPENING: begin
                            n_timer = t_sat;
                            if (ramp_end) begin
                                n_lid   = '0;
                                n_phase = PH_OPEN;
                                n_lfsr  = lfsr_nx;
                                if (r_bmax > r_bmin) begin
                                    div_start = 1'b1;
                                    div_long  = 1'b1;
                                    div_num   = lfsr_nx;
                                    div_den   = {1'b0, r_bmax - r_bmin} + 27'd1;
                                    n_kind    = K_DRAW;
                                end else begin
                                    n_cd = r_bmin;
                                end
                            end else begin
                                div_start = 1'b1;
                                div_rem0  = two_t;
                                div_den   = {1'b0, r_dur};
                                n_kind    = K_OPEN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end

        // final step: eyelid ramp and random interval division results
        if (i_cmd.fin) begin
            n_kind = K_NONE;
            case (r_kind)
                K_CLOSE: n_lid = div_quo[16:0];
                K_OPEN:  n_lid = Q_ONE - div_quo[16:0];
                K_DRAW:  n_cd  = r_bmin + div_rem[25:0];
                default: begin
                end
            endcase
        end

        // expression change
        if (chg_req && chg_tgt != r_shown) begin
            n_faded = r_shown;
            n_shown = chg_tgt;
            n_prog  = '0;
        end

        // register writes that reload state
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEFAULT: begin
                    n_shown  = i_cfg_data[4:0];
                    n_faded  = i_cfg_data[4:0];
                    n_cursor = i_cfg_data[4:0];
                    n_saved  = i_cfg_data[4:0];
                    n_prog   = Q_ONE;
                end
                CFG_SEED: n_lfsr = (i_cfg_data == 32'd0) ? 32'd1 : i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_cfg   <= 6'd1;
            r_fade_time <= 26'd1000000;
            r_dur       <= 26'd200000;
            r_bmin      <= 26'd2000000;
            r_bmax      <= 26'd6000000;
            r_shown     <= '0;
            r_faded     <= '0;
            r_cursor    <= '0;
            r_saved     <= '0;
            r_prog      <= Q_ONE;
            r_lid       <= '0;
            r_boop      <= '0;
            r_timer     <= '0;
            r_cd        <= RST_COUNTDOWN;
            r_phase     <= PH_OPEN;
            r_lfsr      <= 32'd1;
            r_kind      <= K_NONE;
            r_fade_sat  <= 1'b0;
        end else begin
            r_shown    <= n_shown;
            r_faded    <= n_faded;
            r_cursor   <= n_cursor;
            r_saved    <= n_saved;
            r_prog     <= n_prog;
            r_lid      <= n_lid;
            r_boop     <= n_boop;
            r_timer    <= n_timer;
            r_cd       <= n_cd;
            r_phase    <= n_phase;
            r_lfsr     <= n_lfsr;
            r_kind     <= n_kind;
            r_fade_sat <= n_fade_sat;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_EXPR_COUNT: r_cnt_cfg   <= i_cfg_data[5:0];
                    CFG_FADE_TIME:  r_fade_time <= i_cfg_data[25:0];
                    CFG_BLINK_DUR:  r_dur       <= i_cfg_data[25:0];
                    CFG_BLINK_MIN:  r_bmin      <= i_cfg_data[25:0];
                    CFG_BLINK_MAX:  r_bmax      <= i_cfg_data[25:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // input transaction latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_opcode;
            r_dt     <= i_dt_us;
            r_idx    <= i_expr_index;
            r_bt     <= i_boop_time_us;
            r_closed <= i_eyes_closed;
            r_en     <= i_blink_enabled;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_current_expression  <= r_shown;
            o_previous_expression <= r_faded;
            o_fade_weight         <= r_prog;
            o_blink_phase         <= r_phase;
            o_blink_weight        <= r_lid;
            o_boop_active         <= (r_boop != 26'd0);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/febs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// febs_ctrl
// Controller: sequences one transaction through the datapath steps.
// ----------------------------------------------------------------------------
module febs_ctrl import febs_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    input  wire t_status i_sts,
    output t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_FIRST, S_WAIT1, S_MID, S_WAIT2, S_FIN, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // commands and next state
    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_FIRST;
                end
            end
            S_FIRST: begin
                o_cmd.first = 1'b1;
                n_state     = S_WAIT1;
            end
            S_WAIT1: if (!i_sts.div_busy) n_state = S_MID;
            S_MID: begin
                o_cmd.mid = 1'b1;
                n_state   = S_WAIT2;
            end
            S_WAIT2: if (!i_sts.div_busy) n_state = S_FIN;
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // a loaded result is presented on the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("result load did not raise output valid");

    // the divider is idle when its result is consumed
    a_mid_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MID || r_state == S_FIN) |-> !i_sts.div_busy)
        else $error("divider busy at a consuming step");

    // no two transactions captured back to back
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> !o_cmd.capture)
        else $error("second transaction captured while busy");

endmodule
`default_nettype wire

// ===== rtl/core/face_expression_blink_sequencer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// face_expression_blink_sequencer_core
// Expression crossfade, boop timer and eyelid blink sequencer.
// ----------------------------------------------------------------------------
// One transaction is handled at a time and gives one result. Select, boop
// and blink-now events need no division; next and previous take the
// wrapped cursor from a shared restoring divider in its 32-step mode.
// A tick runs up to two divisions on that same divider, one bit per
// cycle: the fade ratio (16 steps), then either an eyelid ramp ratio
// (16 steps) or the random interval modulo (32 steps). The next
// transaction is accepted while the previous result still waits in the
// output register.
// ----------------------------------------------------------------------------
module face_expression_blink_sequencer_core import febs_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [19:0] i_dt_us,
    input  wire logic [4:0]  i_expr_index,
    input  wire logic [25:0] i_boop_time_us,
    input  wire logic        i_eyes_closed,
    input  wire logic        i_blink_enabled,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [4:0]       o_current_expression,
    output logic [4:0]       o_previous_expression,
    output logic [16:0]      o_fade_weight,
    output logic [1:0]       o_blink_phase,
    output logic [16:0]      o_blink_weight,
    output logic             o_boop_active
);

    t_cmd    cmd;
    t_status sts;

    // sequencing
    febs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // state and arithmetic
    febs_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_sts                 (sts),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_opcode              (i_opcode),
        .i_dt_us               (i_dt_us),
        .i_expr_index          (i_expr_index),
        .i_boop_time_us        (i_boop_time_us),
        .i_eyes_closed         (i_eyes_closed),
        .i_blink_enabled       (i_blink_enabled),
        .o_current_expression  (o_current_expression),
        .o_previous_expression (o_previous_expression),
        .o_fade_weight         (o_fade_weight),
        .o_blink_phase         (o_blink_phase),
        .o_blink_weight        (o_blink_weight),
        .o_boop_active         (o_boop_active)
    );

endmodule
`default_nettype wire
